FILE: hw/rtl/ggc_pkg.sv
// ----------------------------------------------------------------------------
// ggc_pkg - shared types and constants for the greedy graph colorer
//
// Input and result word layouts, field widths and the forbidden-bitmap
// row geometry.
// ----------------------------------------------------------------------------
`default_nettype none

package ggc_pkg;

  localparam int NODE_W  = 10;    // neighbor / node index field width
  localparam int COLOR_W = 10;    // color field width
  localparam int COUNT_W = 11;    // colors_used field width
  localparam int NODE_LIMIT = 1 << NODE_W;  // indices the fields can name

  // Forbidden bitmap is kept as rows of ROW_W bits
  localparam int ROW_W   = 32;
  localparam int BIT_W   = 5;

  typedef struct packed {
    logic              restart;
    logic              neighbor_present;
    logic [NODE_W-1:0] neighbor_index;
    logic              last_neighbor;
  } in_t;

  typedef struct packed {
    logic [NODE_W-1:0]  node_index;
    logic [COLOR_W-1:0] color;
    logic [COUNT_W-1:0] colors_used;
    logic               overflow;
  } out_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ggc_ram.sv
// ----------------------------------------------------------------------------
// ggc_ram - generic single-write, single-read RAM
//
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ggc_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write, then register the read word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/greedy_graph_coloring.sv
// ----------------------------------------------------------------------------
// greedy_graph_coloring - streamed greedy colorer of an undirected graph
//
// Nodes arrive in index order as runs of neighbor words. Colors of earlier
// neighbors are marked in a forbidden bitmap; the closing word gets the
// smallest free color and produces one result word.
// ----------------------------------------------------------------------------
//
//   channel | signals                          | moves
//   --------+----------------------------------+---------------------------
//   in      | in_valid_i, in_ready_o, in_i     | one neighbor word
//   out     | out_valid_o, out_ready_i, out_o  | one result word per node
//
// A neighbor word whose neighbor is already colored goes through a node
// color RAM read, a bitmap row read and a bitmap row write. A closing word
// then starts the scan, scans the bitmap rows in turn (up to
// ceil(min(MAX_NODES,1024)/32) of them, none for an overflowed node) and
// emits. Row valid bits clear the bitmap at once, so there is no clearing
// pass after reset. The result sits in an output register; a stalled output
// holds the block only at the emit step of the next closing word.
// ----------------------------------------------------------------------------
`default_nettype none

module greedy_graph_coloring
  import ggc_pkg::*;
#(
  parameter int MAX_NODES = 1024
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_o
);

  // Nodes that can ever be named as neighbors, and bitmap geometry
  localparam int FB    = (MAX_NODES < NODE_LIMIT) ? MAX_NODES : NODE_LIMIT;
  localparam int WORDS = (FB + ROW_W - 1) / ROW_W;
  localparam int NAW   = $clog2(FB);
  localparam int WIW   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int CNW   = $clog2(MAX_NODES + 1);
  localparam int CMPW  = (CNW > COUNT_W) ? CNW : COUNT_W;
  localparam int CAP   = (FB == MAX_NODES) ? MAX_NODES - 1 : FB;

  localparam logic [CNW-1:0]     CN_MAX  = CNW'(MAX_NODES);
  localparam logic [COUNT_W-1:0] CAP_C   = COUNT_W'(CAP);
  localparam logic [COUNT_W-1:0] FB_C    = COUNT_W'(FB);
  localparam logic [WIW-1:0]     LAST_W  = WIW'(WORDS - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_NODE  = 3'd1;
  localparam logic [2:0] S_WORD  = 3'd2;
  localparam logic [2:0] S_START = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0]         state_q, state_d;
  logic [CNW-1:0]     cn_q, cn_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [WORDS-1:0]   fvalid_q, fvalid_d;
  logic               last_q, last_d;
  logic [WIW-1:0]     mark_w_q, mark_w_d;
  logic [BIT_W-1:0]   mark_b_q, mark_b_d;
  logic [WIW-1:0]     scan_w_q, scan_w_d;
  logic [COUNT_W-1:0] color_q, color_d;
  logic               out_valid_q, out_valid_d;
  out_t               out_q, out_d;

  // RAM ports
  logic [COLOR_W-1:0] node_rdata;
  logic               node_we;
  logic [NAW-1:0]     node_waddr;
  logic [ROW_W-1:0]   row_rdata;
  logic               row_we;
  logic [ROW_W-1:0]   row_wdata;
  logic [WIW-1:0]     row_raddr;

  logic               accept;
  logic               mark;
  logic               ovf;
  logic [ROW_W-1:0]   row_word;
  logic               free_any;
  logic [BIT_W-1:0]   free_bit;
  logic [COUNT_W-1:0] cand;
  logic [COUNT_W-1:0] nc_ext;
  logic               out_free;

  ggc_ram #(.WIDTH(COLOR_W), .DEPTH(FB)) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (node_we),
    .waddr_i (node_waddr),
    .wdata_i (color_q[COLOR_W-1:0]),
    .raddr_i (in_i.neighbor_index[NAW-1:0]),
    .rdata_o (node_rdata)
  );

  ggc_ram #(.WIDTH(ROW_W), .DEPTH(WORDS)) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (mark_w_q),
    .wdata_i (row_wdata),
    .raddr_i (row_raddr),
    .rdata_o (row_rdata)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign ovf         = (cn_q == CN_MAX);
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // Neighbor counts only when already colored
  assign mark = in_i.neighbor_present && !in_i.restart &&
                (CMPW'(in_i.neighbor_index) < CMPW'(cn_q));

  assign nc_ext = COUNT_W'(node_rdata);

  // Row word as seen through its valid bit
  always_comb begin
    row_word = '0;
    priority if (state_q == S_WORD) begin
      row_word = fvalid_q[mark_w_q] ? row_rdata : '0;
    end else if (fvalid_q[scan_w_q]) begin
      row_word = row_rdata;
    end else begin
      row_word = '0;
    end
  end

  assign row_wdata = row_word | (ROW_W'(1) << mark_b_q);
  assign row_we    = (state_q == S_WORD);

  // Find lowest clear bit of the scanned row
  always_comb begin
    free_any = 1'b0;
    free_bit = '0;
    for (int i = ROW_W - 1; i >= 0; i--) begin
      if (!row_word[i]) begin
        free_any = 1'b1;
        free_bit = BIT_W'(i);
      end
    end
  end

  assign cand = COUNT_W'({scan_w_q, free_bit});

  // Bitmap read address
  always_comb begin
    unique case (state_q)
      S_NODE:  row_raddr = node_rdata[WIW+BIT_W-1:BIT_W];
      S_SCAN:  row_raddr = WIW'(scan_w_q + 1'b1);
      default: row_raddr = '0;
    endcase
  end

  assign node_we    = (state_q == S_EMIT) && out_free && !ovf &&
                      (CMPW'(cn_q) < CMPW'(FB_C));
  assign node_waddr = cn_q[NAW-1:0];

  // Sequencer
  always_comb begin
    state_d     = state_q;
    cn_d        = cn_q;
    count_d     = count_q;
    fvalid_d    = fvalid_q;
    last_d      = last_q;
    mark_w_d    = mark_w_q;
    mark_b_d    = mark_b_q;
    scan_w_d    = scan_w_q;
    color_d     = color_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          last_d = in_i.last_neighbor;
          if (in_i.restart) begin
            cn_d     = '0;
            count_d  = '0;
            fvalid_d = '0;
          end
          priority if (mark) begin
            state_d = S_NODE;
          end else if (in_i.last_neighbor) begin
            state_d = S_START;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_NODE: begin
        // Color of the neighbor is on the RAM output now
        mark_w_d = node_rdata[WIW+BIT_W-1:BIT_W];
        mark_b_d = node_rdata[BIT_W-1:0];
        priority if (nc_ext < FB_C) begin
          state_d = S_WORD;
        end else if (last_q) begin
          state_d = S_START;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_WORD: begin
        fvalid_d[mark_w_q] = 1'b1;
        state_d = last_q ? S_START : S_IDLE;
      end
      S_START: begin
        scan_w_d = '0;
        color_d  = '0;
        state_d  = ovf ? S_EMIT : S_SCAN;
      end
      S_SCAN: begin
        priority if (free_any) begin
          color_d = (cand < FB_C) ? cand : CAP_C;
          state_d = S_EMIT;
        end else if (scan_w_q == LAST_W) begin
          color_d = CAP_C;
          state_d = S_EMIT;
        end else begin
          scan_w_d = WIW'(scan_w_q + 1'b1);
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d      = 1'b1;
          out_d.node_index = NODE_W'(cn_q);
          out_d.overflow   = ovf;
          out_d.color      = ovf ? '0 : color_q[COLOR_W-1:0];
          out_d.colors_used = count_q;
          if (!ovf) begin
            if (COUNT_W'(color_q + 1'b1) > count_q) begin
              count_d           = COUNT_W'(color_q + 1'b1);
              out_d.colors_used = COUNT_W'(color_q + 1'b1);
            end
            cn_d = CNW'(cn_q + 1'b1);
          end
          fvalid_d = '0;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cn_q        <= '0;
      count_q     <= '0;
      fvalid_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cn_q        <= cn_d;
      count_q     <= count_d;
      fvalid_q    <= fvalid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload and working registers
  always_ff @(posedge clk_i) begin
    last_q   <= last_d;
    mark_w_q <= mark_w_d;
    mark_b_q <= mark_b_d;
    scan_w_q <= scan_w_d;
    color_q  <= color_d;
    out_q    <= out_d;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ggc_checker.sv
// ----------------------------------------------------------------------------
// ggc_checker - port-level checks for the greedy graph colorer
//
// Watches the top-level ports only; attached by the bind below.
// ----------------------------------------------------------------------------
`default_nettype none

module ggc_checker
  import ggc_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_o,
  input wire in_t  in_i,
  input wire logic out_valid_o,
  input wire logic out_ready_i,
  input wire out_t out_o
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o))
    else $error("result word changed while stalled");

  // Overflowed node carries no color
  a_ovf_color: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.overflow |-> out_o.color == '0)
    else $error("overflow result with nonzero color");

  // Assigned color lies below the color count
  a_color_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_o.overflow |-> COUNT_W'(out_o.color) < out_o.colors_used)
    else $error("color not counted in colors_used");

  // Closing word keeps the input stalled while the color is searched
  a_close_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_i.last_neighbor |=> !in_ready_o)
    else $error("input ready right after a closing word");

endmodule

bind greedy_graph_coloring ggc_checker u_ggc_checker (.*);

`default_nettype wire

FILE: tb/greedy_graph_coloring_checker.sv
// ----------------------------------------------------------------------------
// Greedy graph coloring checker
//
// Watches the neighbor and result channels of the colorer. Every accepted
// neighbor word updates a private model of the node colors and the forbidden
// marks. Each closing word queues the result it should produce. Each accepted
// result word is compared field by field with the oldest queued result.
// ----------------------------------------------------------------------------
module greedy_graph_coloring_checker
  import ggc_pkg::*;
#(
  parameter int MAX_NODES = 1024
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_ready_i,
  input  in_t  in_i,
  input  logic out_valid_i,
  input  logic out_ready_i,
  input  out_t out_i,
  output int   pending_o,
  output int   fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Model state of the graph being colored
  int                 cur_node;
  int                 colors_in_use;
  logic [COLOR_W-1:0] node_color [MAX_NODES];
  bit                 forbidden  [MAX_NODES];
  out_t               expected_colors [$];

  initial begin
    pending_o    = 0;
    fail_count_o = 0;
  end

  // Clear the graph: node counter, color count and forbidden marks
  task automatic clear_graph();
    cur_node      = 0;
    colors_in_use = 0;
    foreach (forbidden[i]) forbidden[i] = 1'b0;
  endtask

  // Apply one neighbor word; queue a result when it closes a node
  task automatic color_node_word(input in_t w);
    int   c;
    bit   ovf;
    out_t res;
    if (w.restart) clear_graph();
    // Mark the color of an already colored neighbor
    if (w.neighbor_present && int'(w.neighbor_index) < cur_node &&
        int'(w.neighbor_index) < MAX_NODES)
      forbidden[node_color[w.neighbor_index]] = 1'b1;
    if (w.last_neighbor) begin
      ovf = (cur_node >= MAX_NODES);
      c   = 0;
      if (!ovf) begin
        while (c < MAX_NODES - 1 && forbidden[c]) c++;
        node_color[cur_node] = COLOR_W'(c);
        if (c + 1 > colors_in_use) colors_in_use = c + 1;
      end
      res.node_index  = NODE_W'(cur_node);
      res.color       = COLOR_W'(c);
      res.colors_used = COUNT_W'(colors_in_use);
      res.overflow    = ovf;
      expected_colors.push_back(res);
      foreach (forbidden[i]) forbidden[i] = 1'b0;
      if (!ovf) cur_node++;
    end
  endtask

  // Compare one result field, X counts as wrong
  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  // Pop before push: a result never leaves in the cycle its word arrives
  always @(posedge clk_i or negedge rst_ni) begin
    out_t exp_w;
    if (!rst_ni) begin
      clear_graph();
      expected_colors.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_colors.size() == 0) begin
          $display("%0t: unexpected result word, expected none actual %h",
                   $time, out_i);
          fail_count_o++;
        end else begin
          exp_w = expected_colors.pop_front();
          check_field("node_index", 16'(exp_w.node_index), 16'(out_i.node_index));
          check_field("color", 16'(exp_w.color), 16'(out_i.color));
          check_field("colors_used", 16'(exp_w.colors_used), 16'(out_i.colors_used));
          check_field("overflow", 16'(exp_w.overflow), 16'(out_i.overflow));
        end
      end
      if (in_valid_i && in_ready_i) color_node_word(in_i);
    end
    pending_o = expected_colors.size();
  end

endmodule

FILE: tb/tb_greedy_graph_coloring.sv
// ----------------------------------------------------------------------------
// Greedy graph coloring testbench
//
// Drives directed node runs, many small random graphs and one graph larger
// than the node capacity, under several sender and receiver idling mixes.
// A checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_greedy_graph_coloring;
  import ggc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_NODES = 1024;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  in_t  in_i        = '0;
  logic out_ready_i = 1'b0;
  logic in_ready_o;
  logic out_valid_o;
  out_t out_o;
  int   pending;
  int   fail_count;

  // Stimulus knobs and bookkeeping
  int idle_pct  = 0;
  int stall_pct = 0;
  int node_cnt  = 0;
  int word_cnt  = 0;

  greedy_graph_coloring #(.MAX_NODES(MAX_NODES)) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o)
  );

  greedy_graph_coloring_checker #(.MAX_NODES(MAX_NODES)) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_i        (in_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_i       (out_o),
    .pending_o   (pending),
    .fail_count_o(fail_count)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Stall the result channel at the current rate
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Hand one word over, idling first at the current rate
  task automatic send_word(input in_t w);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i       <= w;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    word_cnt++;
  endtask

  // Hold the sender until every result has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  // Pick a neighbor that is already colored, or any index at node 0
  function automatic int earlier_node(input int k);
    if (k == 0) return $urandom_range(0, NODE_LIMIT - 1);
    return $urandom_range(0, (k > NODE_LIMIT ? NODE_LIMIT : k) - 1);
  endfunction

  // Send one node of a small graph; a clique node lists every earlier node
  task automatic send_node(input bit new_graph, input bit clique);
    int   n;
    int   i;
    int   r;
    in_t  w;
    if (new_graph) node_cnt = 0;
    n = clique ? node_cnt : $urandom_range(0, 5);
    if (n == 0) begin
      w                  = '0;
      w.restart          = new_graph;
      w.neighbor_index   = NODE_W'($urandom_range(0, NODE_LIMIT - 1));
      w.last_neighbor    = 1'b1;
      send_word(w);
    end
    for (i = 0; i < n; i++) begin
      w.restart          = new_graph && i == 0;
      w.neighbor_present = 1'b1;
      if (clique) begin
        w.neighbor_index = NODE_W'(i);
      end else begin
        r = $urandom_range(0, 9);
        if (r <= 5) begin
          w.neighbor_index = NODE_W'(earlier_node(node_cnt));
        end else if (r == 6) begin
          w.neighbor_index = NODE_W'(node_cnt);
        end else if (r == 7) begin
          w.neighbor_present = 1'b0;
          w.neighbor_index   = NODE_W'($urandom_range(0, NODE_LIMIT - 1));
        end else begin
          w.neighbor_index = NODE_W'($urandom_range(0, NODE_LIMIT - 1));
        end
        // Rarely break the run with a restart in the middle of a node
        if ($urandom_range(0, 99) == 0) begin
          w.restart = 1'b1;
          node_cnt  = 0;
        end
      end
      w.last_neighbor = (i == n - 1);
      send_word(w);
    end
    node_cnt++;
  endtask

  // Run small random graphs until the word budget is spent
  task automatic run_graphs(input int words);
    int stop_at;
    int gsize;
    stop_at = word_cnt + words;
    gsize   = 0;
    while (word_cnt < stop_at) begin
      if (node_cnt >= gsize) begin
        gsize = $urandom_range(1, 40);
        send_node(1'b1, 1'b0);
      end else begin
        send_node(1'b0, $urandom_range(0, 19) == 0);
      end
    end
  endtask

  // One graph past capacity: mostly one closing word per node
  task automatic send_big_graph(input int nodes);
    int  j;
    in_t w;
    for (j = 0; j < nodes; j++) begin
      w = '0;
      if ($urandom_range(0, 9) == 0) begin
        w.restart          = (j == 0);
        w.neighbor_present = 1'b1;
        w.neighbor_index   = NODE_W'(earlier_node(j));
        send_word(w);
        w.restart = 1'b0;
      end else begin
        w.restart = (j == 0);
      end
      w.neighbor_present = 1'($urandom_range(0, 1));
      w.neighbor_index   = NODE_W'(earlier_node(j));
      w.last_neighbor    = 1'b1;
      send_word(w);
    end
  endtask

  // Directed words: restart, absent and self neighbors, uncolored and
  // extreme indices, restart in mid node and on a closing word
  task automatic send_directed();
    in_t dir_words [$];
    dir_words = '{
      '{1'b1, 1'b0, 10'd1023, 1'b1},
      '{1'b0, 1'b1, 10'd0,    1'b1},
      '{1'b0, 1'b1, 10'd0,    1'b0},
      '{1'b0, 1'b1, 10'd1,    1'b0},
      '{1'b0, 1'b1, 10'd2,    1'b0},
      '{1'b0, 1'b1, 10'd1023, 1'b0},
      '{1'b0, 1'b0, 10'd1,    1'b1},
      '{1'b0, 1'b1, 10'd2,    1'b0},
      '{1'b0, 1'b1, 10'd1,    1'b1},
      '{1'b0, 1'b1, 10'd3,    1'b0},
      '{1'b0, 1'b1, 10'd0,    1'b0},
      '{1'b0, 1'b1, 10'd2,    1'b1},
      '{1'b0, 1'b1, 10'd5,    1'b1},
      '{1'b1, 1'b1, 10'd0,    1'b0},
      '{1'b0, 1'b0, 10'd682,  1'b1},
      '{1'b1, 1'b1, 10'd0,    1'b1},
      '{1'b0, 1'b1, 10'd0,    1'b1}
    };
    foreach (dir_words[i]) send_word(dir_words[i]);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // No idling
    idle_pct  = 0;
    stall_pct = 0;
    send_directed();
    drain();
    run_graphs(250);
    drain();

    // Idle sender
    idle_pct  = 54;
    stall_pct = 0;
    run_graphs(250);
    drain();

    // Stalling receiver
    idle_pct  = 0;
    stall_pct = 54;
    run_graphs(250);
    drain();

    // Both sides idle, then overrun the node capacity
    idle_pct  = 16;
    stall_pct = 16;
    run_graphs(150);
    send_big_graph(MAX_NODES + 6);
    drain();

    repeat (60) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Bound the run
  initial begin
    #10ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/ggc_pkg.sv
hw/rtl/ggc_ram.sv
hw/rtl/greedy_graph_coloring.sv
hw/rtl/ggc_checker.sv
tb/greedy_graph_coloring_checker.sv
tb/tb_greedy_graph_coloring.sv
